// ----- hdl/smid_pkg.sv -----
package smid_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int ELEM_W           = 32;
   localparam int KIND_W           = 2;

   // request kinds; the unused code behaves as a lookup
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_DEL_WRITE,
      ST_FINISH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic start;      // latch request, clear scan
      logic scan;       // issue next read, compare previous data
      logic ins_write;  // append element, count up
      logic del_read;   // read last entry
      logic del_write;  // move last entry into hit slot, count down
      logic refuse;     // insert refused, store full
      logic rsp_load;   // load result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_done;
      logic is_insert;
      logic is_delete;
      logic present;
      logic full;
      logic rsp_free;
   } status_type;

endpackage

// ----- hdl/smid_ram.sv -----
module smid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/smid_ctrl.sv -----
module smid_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  smid_pkg::status_type  status,
   output smid_pkg::cmd_type     cmd
);

   smid_pkg::state_type state_ff;
   smid_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smid_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smid_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = smid_pkg::ST_SCAN;
            end
         end
         smid_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               state_in = smid_pkg::ST_DECIDE;
            end
         end
         smid_pkg::ST_DECIDE: begin
            if (status.is_delete && status.present) begin
               state_in = smid_pkg::ST_DEL_WRITE;
            end else begin
               state_in = smid_pkg::ST_FINISH;
            end
         end
         smid_pkg::ST_DEL_WRITE: begin
            state_in = smid_pkg::ST_FINISH;
         end
         smid_pkg::ST_FINISH: begin
            if (status.rsp_free) begin
               state_in = smid_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = smid_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         smid_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         smid_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         smid_pkg::ST_DECIDE: begin
            if (status.is_insert && !status.present) begin
               cmd.ins_write = !status.full;
               cmd.refuse    = status.full;
            end
            cmd.del_read = status.is_delete && status.present;
         end
         smid_pkg::ST_DEL_WRITE: begin
            cmd.del_write = 1'b1;
         end
         smid_pkg::ST_FINISH: begin
            cmd.rsp_load = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ----- hdl/smid_datapath.sv -----
module smid_datapath #(
   parameter int CAPACITY = smid_pkg::CAPACITY_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [smid_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [smid_pkg::ELEM_W-1:0]  req_element,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic                                rsp_was_present,
   output logic [$clog2(CAPACITY+1)-1:0]       rsp_count,
   output logic                                rsp_full_refused,
   input  smid_pkg::cmd_type                   cmd,
   output smid_pkg::status_type                status
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [smid_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [smid_pkg::ELEM_W-1:0] elem_ff, elem_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               scan_idx_ff, scan_idx_in;
   logic                        cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0]               cmp_idx_ff, cmp_idx_in;
   logic                        present_ff, present_in;
   logic [AW-1:0]               slot_ff, slot_in;
   logic                        refused_ff, refused_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_present_ff, rsp_present_in;
   logic [CW-1:0]               rsp_count_ff, rsp_count_in;
   logic                        rsp_refused_ff, rsp_refused_in;

   logic [CW-1:0]               last_idx;
   logic                        issue;
   logic                        hit;
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [smid_pkg::ELEM_W-1:0] wr_data;
   logic                        rd_en;
   logic [AW-1:0]               rd_addr;
   logic [smid_pkg::ELEM_W-1:0] rd_data;

   assign last_idx = count_ff - CW'(1);
   assign issue    = scan_idx_ff != count_ff;
   assign hit      = cmp_valid_ff && (rd_data == elem_ff);

   always_comb begin
      // the last entry is compared in the first cycle with nothing left to issue
      status.scan_done = hit || !issue;
      status.is_insert = kind_ff == smid_pkg::KIND_INSERT;
      status.is_delete = kind_ff == smid_pkg::KIND_DELETE;
      status.present   = present_ff;
      status.full      = count_ff == CW'(CAPACITY);
      status.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   // store ports
   always_comb begin
      wr_en   = cmd.ins_write || cmd.del_write;
      wr_addr = cmd.del_write ? slot_ff : count_ff[AW-1:0];
      wr_data = cmd.del_write ? rd_data : elem_ff;
      rd_en   = (cmd.scan && issue) || cmd.del_read;
      rd_addr = cmd.del_read ? last_idx[AW-1:0] : scan_idx_ff[AW-1:0];
   end

   always_comb begin
      kind_in        = kind_ff;
      elem_in        = elem_ff;
      count_in       = count_ff;
      scan_idx_in    = scan_idx_ff;
      cmp_valid_in   = cmp_valid_ff;
      cmp_idx_in     = cmp_idx_ff;
      present_in     = present_ff;
      slot_in        = slot_ff;
      refused_in     = refused_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_present_in = rsp_present_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_refused_in = rsp_refused_ff;

      if (cmd.start) begin
         kind_in      = req_kind;
         elem_in      = req_element;
         scan_idx_in  = '0;
         cmp_valid_in = 1'b0;
         present_in   = 1'b0;
         refused_in   = 1'b0;
      end
      // one read issued and one compare per cycle
      if (cmd.scan) begin
         cmp_valid_in = issue;
         if (issue) begin
            scan_idx_in = scan_idx_ff + CW'(1);
            cmp_idx_in  = scan_idx_ff[AW-1:0];
         end
         if (hit) begin
            present_in = 1'b1;
            slot_in    = cmp_idx_ff;
         end
      end
      if (cmd.ins_write) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.del_write) begin
         count_in = last_idx;
      end
      if (cmd.refuse) begin
         refused_in = 1'b1;
      end
      if (cmd.rsp_load) begin
         rsp_valid_in   = 1'b1;
         rsp_present_in = present_ff;
         rsp_count_in   = count_ff;
         rsp_refused_in = refused_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      elem_ff        <= elem_in;
      scan_idx_ff    <= scan_idx_in;
      cmp_idx_ff     <= cmp_idx_in;
      present_ff     <= present_in;
      slot_ff        <= slot_in;
      refused_ff     <= refused_in;
      rsp_present_ff <= rsp_present_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_refused_ff <= rsp_refused_in;
   end

   smid_ram #(
      .WIDTH (smid_pkg::ELEM_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_was_present  = rsp_present_ff;
   assign rsp_count        = rsp_count_ff;
   assign rsp_full_refused = rsp_refused_ff;

endmodule

// ----- hdl/set_member_insert_delete_core.sv -----
// Set store for up to CAPACITY signed 32-bit values, kept as an unsorted array
// in a single-port-read RAM plus a member count. Each request word (lookup,
// insert or delete) returns one result word with the prior presence flag, the
// count after the request and a flag for an insert refused on a full store.
// When the element is absent a request reads every stored entry (one RAM read
// per entry, compared in the next cycle, then decide and respond); a hit ends
// the scan early, and a delete adds a step to move the last entry into the
// freed slot; the scan through the RAM read port sets the request time.
// Requests are taken one at a time; the result sits in an output register, so
// the next request is taken while an earlier result is still stalled.
module set_member_insert_delete_core #(
   parameter int CAPACITY = smid_pkg::CAPACITY_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [smid_pkg::KIND_W-1:0]         req_kind,
   input  logic signed [smid_pkg::ELEM_W-1:0]  req_element,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_was_present,
   output logic [$clog2(CAPACITY+1)-1:0]       rsp_count,
   output logic                                rsp_full_refused
);

   smid_pkg::cmd_type    cmd;
   smid_pkg::status_type status;

   smid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   smid_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_kind         (req_kind),
      .req_element      (req_element),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_was_present  (rsp_was_present),
      .rsp_count        (rsp_count),
      .rsp_full_refused (rsp_full_refused),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ----- hdl/smid_checker.sv -----
module smid_checker #(
   parameter int CAPACITY = smid_pkg::CAPACITY_DEFAULT
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_was_present,
   input logic [$clog2(CAPACITY+1)-1:0]       rsp_count,
   input logic                                rsp_full_refused
);

   localparam int CW = $clog2(CAPACITY + 1);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_was_present)
         && $stable(rsp_count) && $stable(rsp_full_refused))
      else $error("stalled result word changed");

   // one request in flight: busy right after a request is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= CW'(CAPACITY))
      else $error("count above capacity");

   // refusal only for an absent element on a full store
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_full_refused |-> !rsp_was_present && rsp_count == CW'(CAPACITY))
      else $error("bad refusal");

endmodule

bind set_member_insert_delete_core smid_checker #(
   .CAPACITY (CAPACITY)
) u_smid_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_was_present  (rsp_was_present),
   .rsp_count        (rsp_count),
   .rsp_full_refused (rsp_full_refused)
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

   localparam int CAP   = smid_pkg::CAPACITY_DEFAULT;
   localparam int CNT_W = $clog2(CAP + 1);
   localparam logic [smid_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int POOL_N = 24;

   typedef struct {
      logic [smid_pkg::KIND_W-1:0]        kind;
      logic signed [smid_pkg::ELEM_W-1:0] element;
   } request_type;

   typedef struct {
      logic             was_present;
      logic [CNT_W-1:0] count;
      logic             full_refused;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [smid_pkg::KIND_W-1:0]        req_kind = smid_pkg::KIND_LOOKUP;
   logic signed [smid_pkg::ELEM_W-1:0] req_element = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic                               rsp_was_present;
   logic [CNT_W-1:0]                   rsp_count;
   logic                               rsp_full_refused;

   request_type pending_reqs[$];
   result_type  expected_rsp[$];
   request_type next_req;

   // shadow copy of the set
   logic signed [smid_pkg::ELEM_W-1:0] set_vals[CAP];
   int                                 set_count = 0;

   logic signed [smid_pkg::ELEM_W-1:0] value_pool[POOL_N];

   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   logic want_hold = 1'b0;
   logic long_hold = 1'b0;
   int  errors = 0;

   set_member_insert_delete_core #(.CAPACITY(CAP)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_element      (req_element),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_was_present  (rsp_was_present),
      .rsp_count        (rsp_count),
      .rsp_full_refused (rsp_full_refused)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // applies one request to the shadow set and queues the result it yields
   function automatic void apply_set_request(logic [smid_pkg::KIND_W-1:0] kind,
                                             logic signed [smid_pkg::ELEM_W-1:0] element);
      int         slot;
      result_type r;
      slot = set_count;
      for (int i = 0; i < set_count; i++) begin
         if (set_vals[i] == element) begin
            slot = i;
            break;
         end
      end
      r.was_present  = (slot < set_count);
      r.full_refused = 1'b0;
      if (kind == smid_pkg::KIND_INSERT && !r.was_present) begin
         if (set_count < CAP) begin
            set_vals[set_count] = element;
            set_count++;
         end else begin
            r.full_refused = 1'b1;
         end
      end else if (kind == smid_pkg::KIND_DELETE && r.was_present) begin
         set_vals[slot] = set_vals[set_count-1];
         set_count--;
      end
      r.count = set_count[CNT_W-1:0];
      expected_rsp.push_back(r);
   endfunction

   // request side
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            apply_set_request(req_kind, req_element);
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_req = pending_reqs.pop_front();
               req_valid   <= 1'b1;
               req_kind    <= next_req.kind;
               req_element <= next_req.element;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result side
   always @(posedge clock) begin
      result_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("result word with nothing expected");
               errors++;
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_was_present !== e.was_present) begin
                  $error("was_present: expected %0d, got %0d", e.was_present,
                         rsp_was_present);
                  errors++;
               end
               if (rsp_count !== e.count) begin
                  $error("count: expected %0d, got %0d", e.count, rsp_count);
                  errors++;
               end
               if (rsp_full_refused !== e.full_refused) begin
                  $error("full_refused: expected %0d, got %0d", e.full_refused,
                         rsp_full_refused);
                  errors++;
               end
            end
         end
         rsp_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
      end
   end

   // long receiver hold-off so the core backs up into its request port
   initial begin
      wait (want_hold);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (300) @(posedge clock);
      long_hold <= 1'b0;
   end

   task automatic push_req(logic [smid_pkg::KIND_W-1:0] kind,
                           logic signed [smid_pkg::ELEM_W-1:0] element);
      request_type w;
      w.kind    = kind;
      w.element = element;
      pending_reqs.push_back(w);
   endtask

   // mostly pool values so hits, full stores and deletes happen often
   task automatic push_random_req(int ins_weight);
      int                                 r;
      logic [smid_pkg::KIND_W-1:0]        kind;
      logic signed [smid_pkg::ELEM_W-1:0] element;
      r = $urandom_range(99);
      if (r < 3)
         kind = KIND_UNUSED;
      else if (r < 20)
         kind = smid_pkg::KIND_LOOKUP;
      else if (r < 20 + ins_weight)
         kind = smid_pkg::KIND_INSERT;
      else
         kind = smid_pkg::KIND_DELETE;
      if ($urandom_range(99) < 85)
         element = value_pool[$urandom_range(POOL_N-1)];
      else
         element = $urandom;
      push_req(kind, element);
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (!(pending_reqs.size() == 0 && !req_valid && expected_rsp.size() == 0));
   endtask

   // first half grows the set toward full, second half shrinks it
   task automatic run_phase(int n, int sidle, int rstall);
      @(negedge clock);
      send_idle_pct  = sidle;
      recv_stall_pct = rstall;
      for (int i = 0; i < n; i++)
         push_random_req((i < n / 2) ? 55 : 30);
      wait_drained();
   endtask

   initial begin
      value_pool[0] = 32'sh8000_0000;
      value_pool[1] = 32'sh7fff_ffff;
      value_pool[2] = 32'sh0000_0000;
      value_pool[3] = 32'shffff_ffff;
      for (int i = 4; i < POOL_N; i++)
         value_pool[i] = $urandom;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      push_req(smid_pkg::KIND_LOOKUP, 0);                  // empty set
      push_req(smid_pkg::KIND_DELETE, 5);                  // delete from empty
      push_req(smid_pkg::KIND_INSERT, 32'sh8000_0000);
      push_req(smid_pkg::KIND_INSERT, 32'sh7fff_ffff);
      push_req(smid_pkg::KIND_INSERT, 0);
      push_req(smid_pkg::KIND_INSERT, -1);
      push_req(smid_pkg::KIND_INSERT, 32'sh7fff_ffff);     // already present
      push_req(KIND_UNUSED, 32'sh7fff_ffff);               // acts as lookup, hit
      push_req(KIND_UNUSED, 12345);                        // acts as lookup, miss
      for (int i = 1; i <= CAP - 4; i++)
         push_req(smid_pkg::KIND_INSERT, i);
      push_req(smid_pkg::KIND_INSERT, 99);                 // full, refused
      push_req(smid_pkg::KIND_INSERT, 0);                  // full but present
      push_req(smid_pkg::KIND_DELETE, 32'sh8000_0000);     // first entry
      push_req(smid_pkg::KIND_DELETE, CAP - 4);            // moved into first slot
      push_req(smid_pkg::KIND_DELETE, -1);                 // middle entry
      push_req(smid_pkg::KIND_LOOKUP, 32'sh8000_0000);
      wait_drained();

      // back up the core behind a stalled result port
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      for (int i = 0; i < 40; i++)
         push_random_req(45);
      want_hold = 1'b1;
      wait_drained();

      run_phase(245, 0, 0);
      run_phase(245, 85, 0);
      run_phase(245, 0, 85);
      run_phase(245, 16, 16);

      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("PASS set_member_insert_delete_core");
      else
         $display("FAIL set_member_insert_delete_core");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL set_member_insert_delete_core");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/smid_pkg.sv
hdl/smid_ram.sv
hdl/smid_ctrl.sv
hdl/smid_datapath.sv
hdl/set_member_insert_delete_core.sv
hdl/smid_checker.sv
dv/tb.sv
